[design/tthd_pkg.sv]
// Shared types and constants for the touch tap-and-hold detector.
// Holds the configuration, queue item and result code definitions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tthd_pkg;

    // Configuration register indexes
    localparam logic [2:0] REG_TOUCH_LIMIT   = 3'd0;
    localparam logic [2:0] REG_TAP_WINDOW_MS = 3'd1;
    localparam logic [2:0] REG_TAP_MIN_COUNT = 3'd2;
    localparam logic [2:0] REG_HOLD_MS       = 3'd3;
    localparam logic [2:0] REG_REACTION_MS   = 3'd4;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_TOUCH_LIMIT   = 16'd40;
    localparam logic [15:0] RST_TAP_WINDOW_MS = 16'd2000;
    localparam logic [7:0]  RST_TAP_MIN_COUNT = 8'd3;
    localparam logic [15:0] RST_HOLD_MS       = 16'd500;
    localparam logic [15:0] RST_REACTION_MS   = 16'd3000;

    // Reaction start codes
    localparam logic [1:0] START_NONE = 2'd0;
    localparam logic [1:0] START_HOLD = 2'd1;
    localparam logic [1:0] START_TAPS = 2'd2;

    localparam logic [7:0] TAP_COUNT_MAX = 8'hFF;

    // Queue between front and back; depth is a power of two
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_PTR_W;
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    typedef struct packed {
        logic [15:0] touch_limit;
        logic [15:0] tap_window_ms;
        logic [7:0]  tap_min_count;
        logic [15:0] hold_ms;
        logic [15:0] reaction_ms;
    } cfg_t;

    // Classified sample as it travels from front to back
    typedef struct packed {
        logic        touched;
        logic [31:0] now_ms;
    } item_t;

    // Queue status seen by its neighbors
    typedef struct packed {
        logic can_push;
        logic can_pop;
    } queue_status_t;

endpackage

`default_nettype wire

[design/tthd_front.sv]
// Front stage: accepts samples, classifies touch state, stages the item.
// Depends on tthd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tthd_front
    import tthd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] touch_sample,
    input  wire logic [31:0] now_ms,
    input  wire logic [15:0] touch_limit,
    output logic             push_valid,
    input  wire logic        push_ready,
    output item_t            push_item
);

    logic  stage_valid_reg;
    logic  stage_valid_next;
    item_t stage_item_reg;
    logic  accept;

    assign in_ready   = !stage_valid_reg || push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = stage_valid_reg;
    assign push_item  = stage_item_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Classify: below threshold counts as touched
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg.touched <= (touch_sample < touch_limit);
            stage_item_reg.now_ms  <= now_ms;
        end
    end

endmodule

`default_nettype wire

[design/tthd_queue.sv]
// Short queue decoupling the front stage from the gesture back end.
// Depends on tthd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tthd_queue
    import tthd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output item_t      pop_item,
    output queue_status_t status
);

    item_t                  entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    assign status.can_push = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign status.can_pop  = (count_reg != '0);
    assign do_push         = push && status.can_push;
    assign do_pop          = pop && status.can_pop;
    assign pop_item        = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[design/tthd_back.sv]
// Back end: tap counting, hold timing, reaction timing and result register.
// Depends on tthd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tthd_back
    import tthd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  item_valid,
    output logic       item_pop,
    input  wire item_t item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [1:0] reaction_started,
    output logic       reaction_ended,
    output logic       reaction_on,
    output logic       touch_now
);

    logic        was_touched_reg;
    logic [31:0] press_start_reg;
    logic [7:0]  tap_count_reg;
    logic [31:0] first_tap_reg;
    logic        active_reg;
    logic [31:0] react_start_reg;
    logic        out_valid_reg;

    logic [31:0] press_start_next;
    logic [7:0]  tap_count_next;
    logic [31:0] first_tap_next;
    logic        active_next;
    logic [31:0] react_start_next;
    logic [1:0]  started_next;
    logic        ended_next;

    logic [1:0]  started_reg;
    logic        ended_reg;
    logic        on_reg;
    logic        touch_reg;

    logic        press_edge;
    logic        release_edge;
    logic [31:0] press_diff;
    logic [31:0] first_diff;
    logic [31:0] react_diff;
    logic        in_window;
    logic        load;

    assign load     = item_valid && (!out_valid_reg || out_ready);
    assign item_pop = load;

    assign press_edge   = item.touched && !was_touched_reg;
    assign release_edge = !item.touched && was_touched_reg;

    // A fresh press restarts the hold timer at zero
    assign press_diff = press_edge ? '0 : (item.now_ms - press_start_reg);
    // Only read while released, when the first tap time cannot move
    assign first_diff = item.now_ms - first_tap_reg;
    assign in_window  = (first_diff <= {16'b0, cfg.tap_window_ms});

    always_comb
    begin
        press_start_next = press_start_reg;
        tap_count_next   = tap_count_reg;
        first_tap_next   = first_tap_reg;
        active_next      = active_reg;
        react_start_next = react_start_reg;
        started_next     = START_NONE;

        if (press_edge)
        begin
            press_start_next = item.now_ms;
            if (tap_count_reg == '0)
            begin
                first_tap_next = item.now_ms;
            end
            if (tap_count_reg != TAP_COUNT_MAX)
            begin
                tap_count_next = tap_count_reg + 1'b1;
            end
        end

        // Long hold
        if (item.touched && !active_reg && (press_diff >= {16'b0, cfg.hold_ms}))
        begin
            active_next      = 1'b1;
            react_start_next = item.now_ms;
            tap_count_next   = '0;
            started_next     = START_HOLD;
        end

        // Tap sequence completes on release
        if (release_edge && !active_reg && (tap_count_next >= cfg.tap_min_count)
            && in_window)
        begin
            active_next      = 1'b1;
            react_start_next = item.now_ms;
            started_next     = START_TAPS;
        end

        // Drop a stale tap sequence while released
        if (!item.touched && (tap_count_next != '0) && !in_window)
        begin
            tap_count_next = '0;
        end
    end

    // A reaction started in this transaction has zero elapsed time
    assign react_diff = (started_next != START_NONE) ? '0
                                                    : (item.now_ms - react_start_reg);

    always_comb
    begin
        ended_next = 1'b0;
        if (active_next && (react_diff >= {16'b0, cfg.reaction_ms}))
        begin
            ended_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            was_touched_reg <= 1'b0;
            press_start_reg <= '0;
            tap_count_reg   <= '0;
            first_tap_reg   <= '0;
            active_reg      <= 1'b0;
            react_start_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                was_touched_reg <= item.touched;
                press_start_reg <= press_start_next;
                tap_count_reg   <= tap_count_next;
                first_tap_reg   <= first_tap_next;
                active_reg      <= active_next && !ended_next;
                react_start_reg <= react_start_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            started_reg <= started_next;
            ended_reg   <= ended_next;
            on_reg      <= active_next && !ended_next;
            touch_reg   <= item.touched;
        end
    end

    assign out_valid        = out_valid_reg;
    assign reaction_started = started_reg;
    assign reaction_ended   = ended_reg;
    assign reaction_on      = on_reg;
    assign touch_now        = touch_reg;

    // A hold start needs a touched sample, a tap start a released one
    a_hold_touched : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (started_reg == START_HOLD)) |-> touch_reg)
        else $error("hold start on an untouched sample");

    a_taps_released : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (started_reg == START_TAPS)) |-> !touch_reg)
        else $error("tap start on a touched sample");

    a_end_clears_on : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ended_reg) |-> !on_reg)
        else $error("reaction reported on after it ended");

    a_on_tracks_state : assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (on_reg == active_reg))
        else $error("reported reaction state differs from held state");

endmodule

`default_nettype wire

[design/touch_tap_and_hold_detector_core.sv]
// Top level of the touch tap-and-hold detector.
// Depends on tthd_pkg, tthd_front, tthd_queue and tthd_back.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// - Input channel (in_valid/in_ready): one transaction carries a raw touch
//   sample and its millisecond time stamp. Output channel (out_valid/out_ready):
//   exactly one result transaction per input transaction, in order.
// - Configuration: pulse cfg_wr_en with cfg_index and cfg_wdata; the write
//   lands at that clock edge. Write only while the block is idle.
// - Path: an accepted transaction is registered in the front stage, moves into the
//   queue, and is then loaded from the queue into the result register; it waits
//   longer while the queue holds older transactions.
// - Throughput: one transaction per cycle while out_ready stays high; the back end
//   updates its state per transaction (three 32-bit elapsed-time compares in parallel).
// - Stall: when out_ready is low the result register holds; the two-entry
//   queue and the front stage absorb up to three more transactions before
//   in_ready drops.
// - Reset: all gesture state clears, configuration returns to its default
//   values, queue empties and no result is valid.

module touch_tap_and_hold_detector_core
    import tthd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] touch_sample,
    input  wire logic [31:0] now_ms,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       reaction_started,
    output logic             reaction_ended,
    output logic             reaction_on,
    output logic             touch_now
);

    cfg_t          cfg_reg;
    logic          push_valid;
    item_t         push_item;
    item_t         pop_item;
    logic          pop;
    queue_status_t q_status;

    // Configuration registers; writes to unused indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.touch_limit   <= RST_TOUCH_LIMIT;
            cfg_reg.tap_window_ms <= RST_TAP_WINDOW_MS;
            cfg_reg.tap_min_count <= RST_TAP_MIN_COUNT;
            cfg_reg.hold_ms       <= RST_HOLD_MS;
            cfg_reg.reaction_ms   <= RST_REACTION_MS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TOUCH_LIMIT:   cfg_reg.touch_limit   <= cfg_wdata;
                REG_TAP_WINDOW_MS: cfg_reg.tap_window_ms <= cfg_wdata;
                REG_TAP_MIN_COUNT: cfg_reg.tap_min_count <= cfg_wdata[7:0];
                REG_HOLD_MS:       cfg_reg.hold_ms       <= cfg_wdata;
                REG_REACTION_MS:   cfg_reg.reaction_ms   <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Front: accept and classify each sample
    tthd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .touch_sample (touch_sample),
        .now_ms       (now_ms),
        .touch_limit  (cfg_reg.touch_limit),
        .push_valid   (push_valid),
        .push_ready   (q_status.can_push),
        .push_item    (push_item)
    );

    // Queue: let front and back stall independently
    tthd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_valid),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    // Back: advance gesture state and register the result
    tthd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .item_valid       (q_status.can_pop),
        .item_pop         (pop),
        .item             (pop_item),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .reaction_started (reaction_started),
        .reaction_ended   (reaction_ended),
        .reaction_on      (reaction_on),
        .touch_now        (touch_now)
    );

endmodule

`default_nettype wire

[verif/tthd_tb_pkg.sv]
// Scoreboard for the touch tap-and-hold detector testbench.
// Holds the gesture predictor and the queue of predicted results.
// Depends on tthd_pkg.
`timescale 1ns / 1ps

package tthd_tb_pkg;

    import tthd_pkg::*;

    typedef struct packed {
        logic [1:0] started;
        logic       ended;
        logic       active;
        logic       touched;
    } gesture_result_t;

    class gesture_scoreboard;

        logic [15:0] touch_limit;
        logic [15:0] tap_window_ms;
        logic [7:0]  tap_min_count;
        logic [15:0] hold_ms;
        logic [15:0] reaction_ms;

        logic        was_touched;
        logic [31:0] press_at;
        logic [7:0]  tap_count;
        logic [31:0] first_tap_at;
        logic        reacting;
        logic [31:0] reaction_at;

        gesture_result_t predicted_q[$];
        int errors;

        function new();
            touch_limit     = RST_TOUCH_LIMIT;
            tap_window_ms   = RST_TAP_WINDOW_MS;
            tap_min_count   = RST_TAP_MIN_COUNT;
            hold_ms         = RST_HOLD_MS;
            reaction_ms     = RST_REACTION_MS;
            was_touched     = 1'b0;
            press_at        = '0;
            tap_count       = '0;
            first_tap_at    = '0;
            reacting        = 1'b0;
            reaction_at     = '0;
            errors          = 0;
        endfunction

        // Unknown indexes are dropped; data is cut to the register width
        function void write_register(logic [2:0] index, logic [15:0] data);
            case (index)
                REG_TOUCH_LIMIT:   touch_limit = data;
                REG_TAP_WINDOW_MS: tap_window_ms = data;
                REG_TAP_MIN_COUNT: tap_min_count = data[7:0];
                REG_HOLD_MS:       hold_ms = data;
                REG_REACTION_MS:   reaction_ms = data;
                default: ;
            endcase
        endfunction

        function void note_sample(logic [15:0] sample, logic [31:0] at_ms);
            gesture_result_t res;
            logic            touched;
            logic [31:0]     since_press;
            logic [31:0]     since_first;
            logic [31:0]     since_start;
            touched     = sample < touch_limit;
            res.started = START_NONE;
            res.ended   = 1'b0;
            if (touched && !was_touched)
            begin
                press_at = at_ms;
                if (tap_count == 8'd0)
                    first_tap_at = at_ms;
                if (tap_count != TAP_COUNT_MAX)
                    tap_count = tap_count + 8'd1;
            end
            since_press = at_ms - press_at;
            if (touched && !reacting && since_press >= {16'd0, hold_ms})
            begin
                reacting    = 1'b1;
                reaction_at = at_ms;
                tap_count   = 8'd0;
                res.started = START_HOLD;
            end
            since_first = at_ms - first_tap_at;
            if (!touched && was_touched && !reacting && tap_count >= tap_min_count &&
                since_first <= {16'd0, tap_window_ms})
            begin
                reacting    = 1'b1;
                reaction_at = at_ms;
                res.started = START_TAPS;
            end
            if (tap_count != 8'd0 && !touched && since_first > {16'd0, tap_window_ms})
                tap_count = 8'd0;
            since_start = at_ms - reaction_at;
            if (reacting && since_start >= {16'd0, reaction_ms})
            begin
                reacting  = 1'b0;
                res.ended = 1'b1;
            end
            was_touched = touched;
            res.active  = reacting;
            res.touched = touched;
            predicted_q.push_back(res);
        endfunction

        function void compare_field(string name, logic [1:0] want, logic [1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [1:0] started, logic ended, logic active,
                                   logic touched);
            gesture_result_t want;
            if (predicted_q.size() == 0)
            begin
                $display("%0t: result with none predicted, expected none actual %0d/%0d/%0d/%0d",
                         $time, started, ended, active, touched);
                errors++;
                return;
            end
            want = predicted_q.pop_front();
            compare_field("reaction_started", want.started, started);
            compare_field("reaction_ended", {1'b0, want.ended}, {1'b0, ended});
            compare_field("reaction_on", {1'b0, want.active}, {1'b0, active});
            compare_field("touch_now", {1'b0, want.touched}, {1'b0, touched});
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction

    endclass

endpackage

[verif/testbench.sv]
// Testbench for touch_tap_and_hold_detector_core: gesture stimulus, random stalls,
// and a scoreboard check of every result. Depends on tthd_pkg and tthd_tb_pkg.
`timescale 1ns / 1ps

module testbench;

    import tthd_pkg::*;
    import tthd_tb_pkg::*;

    // Run guard, far above the slowest legal run (~2k transactions, random output stalls)
    localparam int CYCLE_LIMIT   = 500000;
    // Quiet time after the last result before touching config or ending
    localparam int SETTLE_CYCLES = 8;
    // First register index the block does not decode
    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] touch_sample;
    logic [31:0] now_ms;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  reaction_started;
    logic        reaction_ended;
    logic        reaction_on;
    logic        touch_now;

    gesture_scoreboard gestures;

    logic [15:0] cur_threshold;  // threshold last written, steers sample picking
    logic [31:0] stamp;          // running millisecond time stamp
    int          gap_pct;        // chance of an input gap before a transaction
    bit          quiet;          // no idling on either side when set
    int          sent_count;
    int          cycles;

    touch_tap_and_hold_detector_core DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .touch_sample     (touch_sample),
        .now_ms           (now_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .reaction_started (reaction_started),
        .reaction_ended   (reaction_ended),
        .reaction_on      (reaction_on),
        .touch_now        (touch_now)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("touch_tap_and_hold_detector_core test failed");
            $finish;
        end
    end

    // Check every result transaction against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            gestures.check_result(reaction_started, reaction_ended, reaction_on, touch_now);
    end

    // Idle density: none, light or heavy, re-picked every so often
    function automatic int pick_pct();
        int roll;
        roll = $urandom_range(2, 0);
        if (roll == 0)
            return 0;
        if (roll == 1)
            return 15;
        return 40;
    endfunction

    // Result side: drop out_ready in random bursts of stalls
    initial
    begin : result_sink
        int stall_left;
        int stall_pct;
        int span;
        out_ready  = 1'b0;
        stall_left = 0;
        stall_pct  = 0;
        span       = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                stall_pct = pick_pct();
                span      = $urandom_range(80, 20);
            end
            span--;
            if (quiet)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(99, 0) < stall_pct)
            begin
                stall_left = $urandom_range(19, 1) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Pick a raw reading on the requested side of the threshold, edges included
    function automatic logic [15:0] pick_sample(input bit touch);
        int roll;
        roll = $urandom_range(3, 0);
        if (touch && cur_threshold != 16'd0)
        begin
            if (roll == 0)
                return 16'd0;
            if (roll == 1)
                return cur_threshold - 16'd1;
            return 16'($urandom_range(cur_threshold - 16'd1, 0));
        end
        if (roll == 0)
            return 16'hFFFF;
        if (roll == 1)
            return cur_threshold;
        return 16'($urandom_range(16'hFFFF, cur_threshold));
    endfunction

    // Advance the time stamp: mostly small steps, sometimes long jumps or a fresh value
    function automatic void step_clock(input int dt_max, input int jump_pct);
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < jump_pct / 4)
            stamp = $urandom();
        else if (roll < jump_pct)
            stamp = stamp + $urandom_range(70000, 0);
        else
            stamp = stamp + $urandom_range(dt_max, 0);
    endfunction

    // Present one transaction and hold it until accepted
    task automatic send_sample(input logic [15:0] sample, input logic [31:0] at_ms);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(99, 0) < gap_pct)
            gap = $urandom_range(19, 1);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        touch_sample <= sample;
        now_ms       <= at_ms;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        gestures.note_sample(sample, at_ms);
        sent_count++;
        if (sent_count % 40 == 0)
            gap_pct = pick_pct();
    endtask

    task automatic feed(input bit touch, input int dt_max, input int jump_pct);
        step_clock(dt_max, jump_pct);
        send_sample(pick_sample(touch), stamp);
    endtask

    // Drop valid, wait out every predicted result, then let the pipe drain
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (gestures.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One write per cycle; the enable stays high across back-to-back writes
    task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        gestures.write_register(index, data);
        if (index == REG_TOUCH_LIMIT)
            cur_threshold = data;
    endtask

    task automatic set_config(input logic [15:0] threshold, input logic [15:0] window,
                              input logic [15:0] min_taps, input logic [15:0] hold_len,
                              input logic [15:0] reaction_len);
        write_reg(REG_TOUCH_LIMIT, threshold);
        write_reg(REG_TAP_WINDOW_MS, window);
        write_reg(REG_TAP_MIN_COUNT, min_taps);
        write_reg(REG_HOLD_MS, hold_len);
        write_reg(REG_REACTION_MS, reaction_len);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random gestures: tap bursts, holds, released stretches and raw noise.
    // A low tap bound above one forces tap bursts only (counter saturation).
    task automatic run_phase(input int items, input int dt_max, input int jump_pct,
                             input int taps_lo, input int taps_hi);
        int done;
        int kind;
        int count;
        done = 0;
        while (done < items)
        begin
            kind = (taps_lo > 1) ? 0 : $urandom_range(9, 0);
            if (kind < 5)
            begin
                count = $urandom_range(taps_hi, taps_lo);
                repeat (count)
                begin
                    repeat ($urandom_range(2, 1))
                    begin
                        feed(1'b1, dt_max, jump_pct);
                        done++;
                    end
                    repeat ($urandom_range(2, 1))
                    begin
                        feed(1'b0, dt_max, jump_pct);
                        done++;
                    end
                end
            end
            else if (kind < 7)
            begin
                repeat ($urandom_range(12, 1))
                begin
                    feed(1'b1, dt_max, jump_pct);
                    done++;
                end
            end
            else if (kind < 9)
            begin
                repeat ($urandom_range(6, 1))
                begin
                    feed(1'b0, dt_max, jump_pct);
                    done++;
                end
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                begin
                    step_clock(dt_max, 50);
                    send_sample(16'($urandom()), stamp);
                    done++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_TOUCH_LIMIT;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        touch_sample  = '0;
        now_ms        = '0;
        quiet         = 1'b0;
        gap_pct       = 0;
        sent_count    = 0;
        cycles        = 0;
        stamp         = '0;
        cur_threshold = RST_TOUCH_LIMIT;
        gestures      = new();

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed pass on the reset configuration
        send_sample(16'hFFFF, 32'd0);        // released at the top reading
        send_sample(16'd0, 32'd10);          // first tap opens the window
        send_sample(16'd39, 32'd20);         // just below threshold, still held
        send_sample(16'd40, 32'd30);         // at threshold counts as released
        send_sample(16'd0, 32'd100);
        send_sample(16'd100, 32'd150);
        send_sample(16'd0, 32'd200);
        send_sample(16'd40, 32'd250);        // third release inside window: tap start
        send_sample(16'd0, 32'd300);         // press while reacting: no hold check
        send_sample(16'hFFFF, 32'd350);
        send_sample(16'd1000, 32'd2300);     // window runs out while released
        send_sample(16'd1000, 32'd3250);     // reaction times out
        send_sample(16'd0, 32'd4000);
        send_sample(16'd20, 32'd4499);       // one ms short of the hold time
        send_sample(16'd20, 32'd4500);       // hold start, counter cleared
        send_sample(16'd20, 32'd7500);       // reaction ends while still held
        send_sample(16'd20, 32'd7600);       // same press holds again
        send_sample(16'd40, 32'd8000);
        send_sample(16'd9999, 32'd11000);
        send_sample(16'd0, 32'hFFFF_FF00);   // hold across the 32-bit wrap
        send_sample(16'd0, 32'h0000_00F4);
        send_sample(16'd40, 32'h0000_0100);
        stamp = 32'h0000_0200;
        settle();

        // Reset values written back explicitly, longer gestures
        set_config(16'd40, 16'd2000, 16'd3, 16'd500, 16'd3000);
        run_phase(150, 150, 8, 1, 6);
        settle();

        // Short times for dense events
        set_config(16'd1000, 16'd300, 16'd2, 16'd120, 16'd200);
        run_phase(200, 40, 8, 1, 5);
        settle();

        // Top threshold, zero window, zero tap count, zero reaction time
        set_config(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0);
        run_phase(100, 2, 0, 1, 4);
        settle();

        // Zero threshold: nothing ever counts as touched
        set_config(16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF);
        run_phase(40, 3000, 8, 1, 3);
        settle();

        // Zero hold time with the longest reaction
        set_config(16'd20000, 16'hFFFF, 16'd1, 16'd0, 16'hFFFF);
        run_phase(60, 30, 8, 1, 3);
        settle();

        // Tap counter saturation: one burst of more than 255 fast taps
        set_config(16'd32768, 16'hFFFF, 16'd255, 16'hFFFF, 16'd50);
        run_phase(1, 1, 0, 256, 270);
        settle();

        // Random moderate configuration
        set_config(16'($urandom()), 16'($urandom_range(3000, 50)), 16'($urandom_range(4, 1)),
                   16'($urandom_range(400, 20)), 16'($urandom_range(800, 0)));
        run_phase(200, 100, 8, 1, 8);
        settle();

        // Closing stretch with no idling; undecoded indexes and a wide tap count write
        quiet = 1'b1;
        for (int k = 0; k < 3; k++)
            write_reg(REG_SPARE_FIRST + 3'(k), 16'($urandom()));
        set_config(16'd40, 16'd2000, 16'hA503, 16'd500, 16'd3000);
        run_phase(150, 150, 8, 1, 6);
        settle();

        if (gestures.errors == 0 && gestures.pending() == 0)
            $display("touch_tap_and_hold_detector_core test passed");
        else
            $display("touch_tap_and_hold_detector_core test failed");
        $finish;
    end

endmodule

[filelist.f]
design/tthd_pkg.sv
design/tthd_front.sv
design/tthd_queue.sv
design/tthd_back.sv
design/touch_tap_and_hold_detector_core.sv
verif/tthd_tb_pkg.sv
verif/testbench.sv
